@@ rtl/decimal_trie_key_lookup_defines.svh @@
// Assertion macros shared by the decimal trie key lookup RTL.
`ifndef DECIMAL_TRIE_KEY_LOOKUP_DEFINES_SVH
`define DECIMAL_TRIE_KEY_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DTK_ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DTK_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/dtk_pkg.sv @@
// Shared constants, types and helper functions of the decimal trie key lookup.
`timescale 1ns / 1ps

package dtk_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int ID_BITS    = 16;
    localparam int RADIX      = 10;
    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int USED_BITS  = $clog2(NODE_COUNT + 1);
    localparam int DIGIT_W    = 4;
    localparam int ACCT_W     = 16;
    localparam int STATUS_W   = 2;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_MISS = 2'd1;
    localparam status_t ST_FULL = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    typedef logic [NODE_BITS-1:0] node_t;
    typedef logic [RADIX-1:0][NODE_BITS-1:0] row_t;

    typedef struct packed {
        logic               valid;
        logic [ID_BITS-1:0] id;
    } id_entry_t;

    typedef struct packed {
        logic      row_rd_en;
        node_t     row_rd_addr;
        logic      row_wr_en;
        node_t     row_wr_addr;
        row_t      row_wr_data;
        logic      id_rd_en;
        node_t     id_rd_addr;
        logic      id_wr_en;
        node_t     id_wr_addr;
        id_entry_t id_wr_data;
    } store_req_t;

    typedef struct packed {
        row_t      row_rd_data;
        id_entry_t id_rd_data;
    } store_rsp_t;

    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [ACCT_W-1:0] found_id;
    } result_t;

    function automatic logic [ID_BITS-1:0] id_from_acct(input logic [ACCT_W-1:0] acct);
        logic [ID_BITS+ACCT_W-1:0] wide;
        wide = {{ID_BITS{1'b0}}, acct};
        return wide[ID_BITS-1:0];
    endfunction

    function automatic logic [ACCT_W-1:0] acct_from_id(input logic [ID_BITS-1:0] id);
        logic [ID_BITS+ACCT_W-1:0] wide;
        wide = {{ACCT_W{1'b0}}, id};
        return wide[ACCT_W-1:0];
    endfunction

endpackage

@@ rtl/dtk_if.sv @@
// Valid/ready channel interfaces for key digits and lookup results.
`timescale 1ns / 1ps

interface dtk_digit_if;
    import dtk_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [DIGIT_W-1:0] digit;
    logic              last_digit;
    logic [ACCT_W-1:0] account_id;

    modport source (output valid, cmd, digit, last_digit, account_id, input ready);
    modport sink   (input valid, cmd, digit, last_digit, account_id, output ready);
endinterface

interface dtk_result_if;
    import dtk_pkg::*;

    logic              valid;
    logic              ready;
    status_t           status;
    logic [ACCT_W-1:0] found_id;

    modport source (output valid, status, found_id, input ready);
    modport sink   (input valid, status, found_id, output ready);
endinterface

@@ rtl/dtk_node_store.sv @@
// Node pool memories: one row of child links per node and one id entry per node.
`timescale 1ns / 1ps

module dtk_node_store (
    input  logic                clk,
    input  dtk_pkg::store_req_t store_req,
    output dtk_pkg::store_rsp_t store_rsp
);
    import dtk_pkg::*;

    row_t      row_mem [NODE_COUNT];
    id_entry_t id_mem  [NODE_COUNT];
    row_t      row_q;
    id_entry_t id_q;

    // Link rows: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (store_req.row_wr_en)
        begin
            row_mem[store_req.row_wr_addr] <= store_req.row_wr_data;
        end
        if (store_req.row_rd_en)
        begin
            row_q <= row_mem[store_req.row_rd_addr];
        end
    end

    // Id entries: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (store_req.id_wr_en)
        begin
            id_mem[store_req.id_wr_addr] <= store_req.id_wr_data;
        end
        if (store_req.id_rd_en)
        begin
            id_q <= id_mem[store_req.id_rd_addr];
        end
    end

    assign store_rsp.row_rd_data = row_q;
    assign store_rsp.id_rd_data  = id_q;

endmodule

@@ rtl/dtk_walk_ctrl.sv @@
// Trie walk sequencer: clearing pass, per-digit link read-modify-write, result build.
`timescale 1ns / 1ps

module dtk_walk_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    dtk_digit_if.sink           key_digit,
    output dtk_pkg::store_req_t store_req,
    input  dtk_pkg::store_rsp_t store_rsp,
    output dtk_pkg::result_t    res,
    input  logic                res_take
);
    import dtk_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_RES
    } state_t;

    state_t                state_reg;
    node_t                 clear_cnt_reg;
    node_t                 cursor_reg;
    logic [USED_BITS-1:0]  nodes_used_reg;
    status_t               key_failed_reg;
    status_t               res_status_reg;
    logic                  res_use_id_reg;

    logic                  cmd_reg;
    logic [DIGIT_W-1:0]    digit_reg;
    logic                  last_reg;
    logic [ACCT_W-1:0]     acct_reg;

    logic                  digit_ok;
    node_t                 link;
    node_t                 next_node;
    logic                  alloc;
    status_t               walk_fail;
    status_t               fail_now;
    row_t                  new_row;
    logic                  id_store;
    logic                  id_fetch;

    // Walk one link of the current node.
    always_comb
    begin
        digit_ok  = digit_reg < DIGIT_W'(RADIX);
        link      = '0;
        next_node = cursor_reg;
        alloc     = 1'b0;
        walk_fail = ST_OK;
        new_row   = store_rsp.row_rd_data;
        if (digit_ok)
        begin
            link = store_rsp.row_rd_data[digit_reg];
        end
        if (key_failed_reg == ST_OK)
        begin
            priority if (!digit_ok)
            begin
                walk_fail = ST_MISS;
            end
            else if (link != '0)
            begin
                next_node = link;
            end
            else if (cmd_reg == CMD_FIND)
            begin
                walk_fail = ST_MISS;
            end
            else if (nodes_used_reg == USED_BITS'(NODE_COUNT))
            begin
                walk_fail = ST_FULL;
            end
            else
            begin
                alloc     = 1'b1;
                next_node = nodes_used_reg[NODE_BITS-1:0];
                new_row[digit_reg] = nodes_used_reg[NODE_BITS-1:0];
            end
        end
        fail_now = (key_failed_reg != ST_OK) ? key_failed_reg : walk_fail;
        id_store = (state_reg == S_WALK) && last_reg && (fail_now == ST_OK)
                   && (cmd_reg == CMD_INSERT);
        id_fetch = (state_reg == S_WALK) && last_reg && (fail_now == ST_OK)
                   && (cmd_reg == CMD_FIND);
    end

    // Memory requests.
    always_comb
    begin
        store_req.row_rd_en   = (state_reg == S_IDLE);
        store_req.row_rd_addr = cursor_reg;
        store_req.row_wr_en   = (state_reg == S_CLEAR) || ((state_reg == S_WALK) && alloc);
        store_req.row_wr_addr = (state_reg == S_CLEAR) ? clear_cnt_reg : cursor_reg;
        store_req.row_wr_data = (state_reg == S_CLEAR) ? '0 : new_row;
        store_req.id_rd_en    = id_fetch;
        store_req.id_rd_addr  = next_node;
        store_req.id_wr_en    = (state_reg == S_CLEAR) || id_store;
        store_req.id_wr_addr  = (state_reg == S_CLEAR) ? clear_cnt_reg : next_node;
        if (state_reg == S_CLEAR)
        begin
            store_req.id_wr_data = '0;
        end
        else
        begin
            store_req.id_wr_data.valid = 1'b1;
            store_req.id_wr_data.id    = id_from_acct(acct_reg);
        end
    end

    assign key_digit.ready = (state_reg == S_IDLE);

    // Result of the key; a find reads its status from the fetched id entry.
    always_comb
    begin
        res.valid    = (state_reg == S_RES);
        res.status   = res_status_reg;
        res.found_id = '0;
        if (res_use_id_reg)
        begin
            if (store_rsp.id_rd_data.valid)
            begin
                res.status   = ST_OK;
                res.found_id = acct_from_id(store_rsp.id_rd_data.id);
            end
            else
            begin
                res.status = ST_MISS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clear_cnt_reg  <= '0;
            cursor_reg     <= '0;
            nodes_used_reg <= USED_BITS'(1);
            key_failed_reg <= ST_OK;
            res_status_reg <= ST_OK;
            res_use_id_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clear_cnt_reg <= clear_cnt_reg + 1'b1;
                    if (clear_cnt_reg == NODE_BITS'(NODE_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (key_digit.valid)
                    begin
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (alloc)
                    begin
                        nodes_used_reg <= nodes_used_reg + 1'b1;
                    end
                    if (last_reg)
                    begin
                        cursor_reg     <= '0;
                        key_failed_reg <= ST_OK;
                        res_status_reg <= fail_now;
                        res_use_id_reg <= id_fetch;
                        state_reg      <= S_RES;
                    end
                    else
                    begin
                        cursor_reg     <= next_node;
                        key_failed_reg <= fail_now;
                        state_reg      <= S_IDLE;
                    end
                end
                S_RES:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Hold the accepted digit for its walk cycle.
    always_ff @(posedge clk)
    begin
        if (key_digit.valid && key_digit.ready)
        begin
            cmd_reg   <= key_digit.cmd;
            digit_reg <= key_digit.digit;
            last_reg  <= key_digit.last_digit;
            acct_reg  <= key_digit.account_id;
        end
    end

endmodule

@@ rtl/decimal_trie_key_lookup.sv @@
// Top level of the decimal trie key lookup: walk sequencer, node store, result register.
//
//  Channel    Role   Payload                               Transfer
//  key_digit  sink   cmd, digit, last_digit, account_id    one key digit
//  result     source status, found_id                      one result per key
//
//  For a digit that is not the last, the transfer cycle reads the
//  cursor's link row and the next cycle walks it and writes back a new link.
//  A last digit then enters a result state, which builds the result from the
//  walk status or the fetched id entry. After reset a clearing pass over all
//  NODE_COUNT (1024) nodes empties both memories, with key_digit.ready held low.
//  A result waits in the output register; the walk stalls only if a new
//  result is ready while the previous one is still not taken.
`timescale 1ns / 1ps

`include "decimal_trie_key_lookup_defines.svh"

module decimal_trie_key_lookup (
    input  logic        clk,
    input  logic        rst_n,
    dtk_digit_if.sink   key_digit,
    dtk_result_if.source result
);
    import dtk_pkg::*;

    store_req_t        store_req;
    store_rsp_t        store_rsp;
    result_t           res;
    logic              res_take;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [ACCT_W-1:0] out_found_id_reg;

    dtk_walk_ctrl u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_digit (key_digit),
        .store_req (store_req),
        .store_rsp (store_rsp),
        .res       (res),
        .res_take  (res_take)
    );

    dtk_node_store u_store (
        .clk       (clk),
        .store_req (store_req),
        .store_rsp (store_rsp)
    );

    // Load the output register when it is empty or being drained this cycle.
    assign res_take = res.valid && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output register; hold while the sink stalls.
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_status_reg   <= res.status;
            out_found_id_reg <= res.found_id;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.status   = out_status_reg;
    assign result.found_id = out_found_id_reg;

    // Each digit needs its walk cycle before the next transfer.
    `DTK_ASSERT_NEXT(a_digit_gap, clk, rst_n, key_digit.valid && key_digit.ready, !key_digit.ready, "digit accepted in back-to-back cycles")

    // Only the three defined status codes leave the block.
    `DTK_ASSERT_IMPLIES(a_status_code, clk, rst_n, result.valid, result.status == ST_OK || result.status == ST_MISS || result.status == ST_FULL, "undefined status code")

    // A failed key never reports an id.
    `DTK_ASSERT_IMPLIES(a_fail_no_id, clk, rst_n, result.valid && result.status != ST_OK, result.found_id == '0, "id reported on a failed key")

    // A new result never overwrites one that is still pending.
    `DTK_ASSERT_NEXT(a_no_overrun, clk, rst_n, out_valid_reg && !result.ready && !res_take, out_valid_reg && $stable(out_found_id_reg), "pending result lost")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the decimal trie key lookup: digit stimulus, trie predictor, result check.
`timescale 1ns / 1ps

module testbench;
    import dtk_pkg::*;

    // Longest key the stimulus builds, in digits.
    localparam int MAX_KEY_DIGITS  = 12;
    localparam int DIRECTED_ROWS   = 25;
    localparam int MIX_DIGITS      = 60;
    localparam int CALM_DIGITS     = 300;
    localparam int TAIL_DIGITS     = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int PRINT_CAP       = 100;

    // One key result as the block reports it.
    typedef struct packed {
        status_t           status;
        logic [ACCT_W-1:0] found_id;
    } key_result_t;

    // One row of the directed table; 'typed' marks a row whose result is written in.
    typedef struct packed {
        logic               cmd;
        logic [DIGIT_W-1:0] digit;
        logic               last;
        logic [ACCT_W-1:0]  acct;
        logic               typed;
        status_t            status;
        logic [ACCT_W-1:0]  found_id;
    } directed_row_t;

    // A whole key: digit count and digits, first digit in slot 0.
    typedef struct packed {
        logic [3:0]                               n;
        logic [MAX_KEY_DIGITS-1:0][DIGIT_W-1:0]   d;
    } key_t;

    // Directed part: extremes of the fields, both commands and each special case.
    localparam directed_row_t DIRECTED_STIM [DIRECTED_ROWS] = '{
        // find in the empty trie right after reset misses
        '{CMD_FIND,   4'd5,  1'b1, 16'h0000, 1'b1, ST_MISS, 16'h0000},
        // single-digit insert, then find it back with the top id
        '{CMD_INSERT, 4'd5,  1'b1, 16'hFFFF, 1'b1, ST_OK,   16'h0000},
        '{CMD_FIND,   4'd5,  1'b1, 16'h0000, 1'b1, ST_OK,   16'hFFFF},
        // two-digit key with the lowest id, lowest and highest digit
        '{CMD_INSERT, 4'd0,  1'b0, 16'hFFFF, 1'b0, ST_OK,   16'h0000},
        '{CMD_INSERT, 4'd9,  1'b1, 16'h0000, 1'b1, ST_OK,   16'h0000},
        '{CMD_FIND,   4'd0,  1'b0, 16'h5555, 1'b0, ST_OK,   16'h0000},
        '{CMD_FIND,   4'd9,  1'b1, 16'hAAAA, 1'b0, ST_OK,   16'h0000},
        // prefix node exists but holds no id
        '{CMD_FIND,   4'd0,  1'b1, 16'h0000, 1'b1, ST_MISS, 16'h0000},
        // bad digit fails the key, the later good digit is ignored
        '{CMD_INSERT, 4'd15, 1'b0, 16'h0000, 1'b0, ST_OK,   16'h0000},
        '{CMD_INSERT, 4'd3,  1'b1, 16'h1111, 1'b1, ST_MISS, 16'h0000},
        '{CMD_FIND,   4'd12, 1'b1, 16'h0000, 1'b1, ST_MISS, 16'h0000},
        // repeated insert overwrites the id
        '{CMD_INSERT, 4'd5,  1'b1, 16'h8001, 1'b0, ST_OK,   16'h0000},
        '{CMD_FIND,   4'd5,  1'b1, 16'h0000, 1'b0, ST_OK,   16'h0000},
        // per-digit command: insert walk, find on the final digit
        '{CMD_INSERT, 4'd0,  1'b0, 16'h0000, 1'b0, ST_OK,   16'h0000},
        '{CMD_FIND,   4'd9,  1'b1, 16'h0000, 1'b0, ST_OK,   16'h0000},
        // miss on the first digit, the insert on the final digit is ignored
        '{CMD_FIND,   4'd7,  1'b0, 16'h0000, 1'b0, ST_OK,   16'h0000},
        '{CMD_INSERT, 4'd7,  1'b1, 16'h5A5A, 1'b1, ST_MISS, 16'h0000},
        // insert creates a node, the final find walks off it
        '{CMD_INSERT, 4'd2,  1'b0, 16'h0000, 1'b0, ST_OK,   16'h0000},
        '{CMD_FIND,   4'd2,  1'b1, 16'h7777, 1'b0, ST_OK,   16'h0000},
        // three-digit key, then find it
        '{CMD_INSERT, 4'd9,  1'b0, 16'h0000, 1'b0, ST_OK,   16'h0000},
        '{CMD_INSERT, 4'd9,  1'b0, 16'h0000, 1'b0, ST_OK,   16'h0000},
        '{CMD_INSERT, 4'd9,  1'b1, 16'hA5A5, 1'b0, ST_OK,   16'h0000},
        '{CMD_FIND,   4'd9,  1'b0, 16'h0000, 1'b0, ST_OK,   16'h0000},
        '{CMD_FIND,   4'd9,  1'b0, 16'h0000, 1'b0, ST_OK,   16'h0000},
        '{CMD_FIND,   4'd9,  1'b1, 16'h0000, 1'b0, ST_OK,   16'h0000}
    };

    logic clk = 1'b0;
    logic rst_n;

    dtk_digit_if  digit_ch ();
    dtk_result_if result_ch ();

    decimal_trie_key_lookup DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_digit(digit_ch),
        .result   (result_ch)
    );

    // Shadow trie: links, ids, pool fill, and the walk of the key in flight.
    node_t       trie_link [NODE_COUNT*RADIX];
    id_entry_t   trie_id [NODE_COUNT];
    int          trie_nodes_used;
    node_t       walk_cursor;
    status_t     walk_fail;

    key_result_t expected_results[$];
    key_t        stored_keys[$];

    int digits_sent;
    int results_seen;
    int ok_seen;
    int miss_seen;
    int full_seen;
    int mismatches;
    int cycle_count;
    int hold_off_left;
    bit calm;

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Advance the shadow trie by one digit; return 1 when the digit closes a key.
    function automatic bit trie_step(input logic cmd, input logic [DIGIT_W-1:0] digit,
                                     input logic last, input logic [ACCT_W-1:0] acct,
                                     output key_result_t res);
        int    slot;
        node_t child;
        res = '{status: ST_OK, found_id: '0};
        if (walk_fail == ST_OK)
        begin
            if (digit >= RADIX)
                walk_fail = ST_MISS;
            else
            begin
                slot  = int'(walk_cursor) * RADIX + int'(digit);
                child = trie_link[slot];
                if (child == '0 && cmd == CMD_FIND)
                    walk_fail = ST_MISS;
                else if (child == '0 && trie_nodes_used >= NODE_COUNT)
                    walk_fail = ST_FULL;
                else
                begin
                    if (child == '0)
                    begin
                        child = node_t'(trie_nodes_used);
                        trie_nodes_used++;
                        trie_link[slot] = child;
                    end
                    walk_cursor = child;
                end
            end
        end
        if (!last)
            return 1'b0;
        if (walk_fail != ST_OK)
            res.status = walk_fail;
        else if (cmd == CMD_INSERT)
            trie_id[walk_cursor] = '{valid: 1'b1, id: acct};
        else if (trie_id[walk_cursor].valid)
            res.found_id = trie_id[walk_cursor].id;
        else
            res.status = ST_MISS;
        walk_cursor = '0;
        walk_fail   = ST_OK;
        return 1'b1;
    endfunction

    // Offer one digit, hold it until the transfer, then queue what it should produce.
    task automatic send_digit(input logic cmd, input logic [DIGIT_W-1:0] digit,
                              input logic last, input logic [ACCT_W-1:0] acct,
                              input bit typed, input key_result_t typed_res);
        key_result_t res;
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 25)
        begin
            digit_ch.valid <= 1'b0;
            @(negedge clk);
        end
        digit_ch.valid      <= 1'b1;
        digit_ch.cmd        <= cmd;
        digit_ch.digit      <= digit;
        digit_ch.last_digit <= last;
        digit_ch.account_id <= acct;
        do
            @(posedge clk);
        while (!digit_ch.ready);
        digits_sent++;
        if (trie_step(cmd, digit, last, acct, res))
            expected_results.push_back(typed ? typed_res : res);
    endtask

    // Send a key digit by digit; cmds gives the command of each digit.
    task automatic send_key(input key_t k, input logic [MAX_KEY_DIGITS-1:0] cmds,
                            input logic [ACCT_W-1:0] acct);
        for (int i = 0; i < int'(k.n); i++)
            send_digit(cmds[i], k.d[i], i == int'(k.n) - 1,
                       (i == int'(k.n) - 1) ? acct : ACCT_W'($urandom()), 1'b0, '0);
    endtask

    function automatic key_t make_key(input int min_len, input int max_len, input int top_digit);
        key_t k;
        k   = '0;
        k.n = 4'($urandom_range(min_len, max_len));
        for (int i = 0; i < MAX_KEY_DIGITS; i++)
            k.d[i] = DIGIT_W'($urandom_range(0, top_digit));
        return k;
    endfunction

    // One key of the random mix: new inserts, overwrites, finds that hit,
    // finds that miss, mixed commands, and keys broken by a bad digit.
    task automatic send_random_key(input int max_len);
        key_t                      k;
        logic [MAX_KEY_DIGITS-1:0] cmds;
        logic [ACCT_W-1:0]         acct;
        int                        pick;
        pick = $urandom_range(0, 99);
        acct = ACCT_W'($urandom());
        k    = make_key(1, max_len, $urandom_range(0, 1) ? 9 : 3);
        cmds = '1;
        if (pick < 30)
        begin
            cmds = '0;
            stored_keys.push_back(k);
        end
        else if (pick < 40 && stored_keys.size() > 0)
        begin
            cmds = '0;
            k    = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        end
        else if (pick < 70 && stored_keys.size() > 0)
            k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else if (pick < 80)
            cmds = '1;
        else if (pick < 90)
            cmds = MAX_KEY_DIGITS'($urandom());
        else
        begin
            cmds = MAX_KEY_DIGITS'($urandom());
            k.d[$urandom_range(0, int'(k.n) - 1)] = DIGIT_W'($urandom_range(10, 15));
        end
        send_key(k, cmds, acct);
    endtask

    // Result receiver: random stalls, a calm stretch, and one long hold-off.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_off_left--;
            end
            else if (calm)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(0, 99) >= 25);
        end
    end

    // Check every result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        key_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result status %0d id %h",
                                          result_ch.status, result_ch.found_id));
            else
            begin
                want = expected_results.pop_front();
                if (result_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              result_ch.status, want.status));
                if (result_ch.found_id !== want.found_id)
                    report_mismatch($sformatf("found_id %h, expected %h",
                                              result_ch.found_id, want.found_id));
                case (want.status)
                    ST_OK:   ok_seen++;
                    ST_MISS: miss_seen++;
                    default: full_seen++;
                endcase
            end
        end
    end

    initial
    begin
        key_result_t typed_res;
        int          fill_start;
        int          tail_end;
        bit          held_off;

        // Hold every input at a known value; assert reset.
        rst_n               = 1'b0;
        digit_ch.valid      = 1'b0;
        digit_ch.cmd        = CMD_INSERT;
        digit_ch.digit      = '0;
        digit_ch.last_digit = 1'b0;
        digit_ch.account_id = '0;
        calm                = 1'b0;
        held_off            = 1'b0;

        // Empty shadow trie, root only.
        for (int i = 0; i < NODE_COUNT * RADIX; i++)
            trie_link[i] = '0;
        for (int i = 0; i < NODE_COUNT; i++)
            trie_id[i] = '0;
        trie_nodes_used = 1;
        walk_cursor     = '0;
        walk_fail       = ST_OK;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table. The block keeps ready low through its clearing pass.
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            typed_res = '{status: DIRECTED_STIM[r].status, found_id: DIRECTED_STIM[r].found_id};
            send_digit(DIRECTED_STIM[r].cmd, DIRECTED_STIM[r].digit, DIRECTED_STIM[r].last,
                       DIRECTED_STIM[r].acct, DIRECTED_STIM[r].typed, typed_res);
        end

        // Random mix of short keys; partway in, stall the receiver long enough
        // that the result register fills and the digit input backs up.
        while (digits_sent < DIRECTED_ROWS + MIX_DIGITS)
        begin
            if (!held_off && digits_sent >= DIRECTED_ROWS + MIX_DIGITS / 3)
            begin
                hold_off_left = HOLD_OFF_CYCLES;
                held_off      = 1'b1;
            end
            send_random_key(4);
        end

        // Fill the node pool with long inserts, with finds of stored keys mixed in.
        // Drop all idling for the first stretch.
        fill_start = digits_sent;
        while (trie_nodes_used < NODE_COUNT)
        begin
            calm = (digits_sent - fill_start) < CALM_DIGITS;
            if ($urandom_range(0, 99) < 5)
                send_key(stored_keys[$urandom_range(0, stored_keys.size() - 1)], '1,
                         ACCT_W'($urandom()));
            else
            begin
                stored_keys.push_back(make_key(MAX_KEY_DIGITS, MAX_KEY_DIGITS, 9));
                send_key(stored_keys[$], '0, ACCT_W'($urandom()));
            end
        end
        calm = 1'b0;

        // Full pool: new paths fail, existing keys still insert and find.
        tail_end = digits_sent + TAIL_DIGITS;
        while (digits_sent < tail_end)
            send_random_key(8);

        @(negedge clk);
        digit_ch.valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d key digits; checked %0d results (%0d done/found, %0d not found, %0d pool full).",
                 digits_sent, results_seen, ok_seen, miss_seen, full_seen);
        $display("Trie reached %0d of %0d nodes; %0d keys stored; one receiver hold-off of %0d cycles.",
                 trie_nodes_used, NODE_COUNT, stored_keys.size(), HOLD_OFF_CYCLES);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
